// ===== hw/rtl/rhsv_pkg.sv =====
// Shared constants, types and stage payload for the RGB to HSV pixel pipeline.
package rhsv_pkg;

  // Channel and hue formats
  localparam int CHANNEL_BITS  = 8;
  localparam int HUE_FRAC_BITS = 6;
  localparam int CHAN_MAX      = (1 << CHANNEL_BITS) - 1;
  localparam int SECTOR        = 60 << HUE_FRAC_BITS;
  localparam int CIRCLE        = 360 << HUE_FRAC_BITS;
  localparam int HUE_BITS      = $clog2(CIRCLE);

  // Divider sizing: one quotient bit per pipeline stage
  localparam int HUE_Q_BITS    = $clog2(SECTOR + 1);
  localparam int DIV_STEPS     = (HUE_Q_BITS > CHANNEL_BITS) ? HUE_Q_BITS : CHANNEL_BITS;
  localparam int ACC_BITS      = CHANNEL_BITS + DIV_STEPS;

  // Hue sector, in priority order red, green, blue
  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } rhsv_sector_t;

  // Payload carried through the divider stages.
  // Each accumulator holds {partial remainder, numerator/quotient bits}.
  typedef struct packed {
    logic [ACC_BITS-1:0]     hue_acc;
    logic [ACC_BITS-1:0]     sat_acc;
    logic [CHANNEL_BITS-1:0] delta;
    logic [CHANNEL_BITS-1:0] vmax;
    rhsv_sector_t            sector;
    logic                    neg;
    logic                    flat;
  } rhsv_stage_t;

endpackage

// ===== hw/rtl/rgb_to_hsv_pixel_unit.sv =====
// Top level of the RGB to HSV pixel pipeline.
// Converts one 8-bit RGB pixel per clock while the output is not stalled
// into hue (degrees, unsigned Q9.6, 0 to 23039), saturation
// floor(255*(max-min)/max) and brightness (the largest channel); equal
// channels give hue and saturation of 0, and ties for the largest channel
// resolve red over green over blue. The pipeline has two front stages for
// max/min and the numerators, one stage per quotient bit of the two pipelined
// restoring dividers, and one output register. Every stage holds its own
// valid bit and accepts a new transaction whenever it is empty or its
// successor moves, so one pixel per clock is kept while the output is ready,
// and a stalled output only backs up the stages behind it.
module rgb_to_hsv_pixel_unit
  import rhsv_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [CHANNEL_BITS-1:0] in_red,
  input  logic [CHANNEL_BITS-1:0] in_green,
  input  logic [CHANNEL_BITS-1:0] in_blue,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [HUE_BITS-1:0]     out_hue,
  output logic [CHANNEL_BITS-1:0] out_saturation,
  output logic [CHANNEL_BITS-1:0] out_brightness
);

  logic [DIV_STEPS:0] chain_valid;
  logic [DIV_STEPS:0] chain_ready;
  rhsv_stage_t        chain_data [DIV_STEPS+1];

  // Max/min selection and numerators
  rhsv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .out_valid (chain_valid[0]),
    .out_ready (chain_ready[0]),
    .out_data  (chain_data[0])
  );

  // One divider stage per quotient bit
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    rhsv_div_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (chain_valid[i]),
      .in_ready  (chain_ready[i]),
      .in_data   (chain_data[i]),
      .out_valid (chain_valid[i+1]),
      .out_ready (chain_ready[i+1]),
      .out_data  (chain_data[i+1])
    );
  end

  // Hue assembly and output register
  rhsv_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (chain_valid[DIV_STEPS]),
    .in_ready       (chain_ready[DIV_STEPS]),
    .in_data        (chain_data[DIV_STEPS]),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hue        (out_hue),
    .out_saturation (out_saturation),
    .out_brightness (out_brightness)
  );

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hue < HUE_BITS'(CIRCLE)))
    else $error("hue outside full circle");

  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_brightness == '0) |-> (out_saturation == '0 && out_hue == '0))
    else $error("black pixel with non-zero hue or saturation");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while output stage is empty");

endmodule

// ===== hw/rtl/rhsv_front.sv =====
// Front end: channel max/min, sector choice, then divider numerators (two stages).
module rhsv_front
  import rhsv_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [CHANNEL_BITS-1:0] in_red,
  input  logic [CHANNEL_BITS-1:0] in_green,
  input  logic [CHANNEL_BITS-1:0] in_blue,
  output logic                    out_valid,
  input  logic                    out_ready,
  output rhsv_stage_t             out_data
);

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] vmax;
    logic [CHANNEL_BITS-1:0] delta;
    logic [CHANNEL_BITS-1:0] absdiff;
    rhsv_sector_t            sector;
    logic                    neg;
  } rhsv_sel_t;

  logic        sel_valid_r;
  logic        sel_ready;
  rhsv_sel_t   sel_r;
  rhsv_sel_t   sel_nxt;
  logic        num_valid_r;
  rhsv_stage_t num_r;
  rhsv_stage_t num_nxt;

  logic [CHANNEL_BITS-1:0] vmax;
  logic [CHANNEL_BITS-1:0] vmin;
  logic [CHANNEL_BITS-1:0] op_p;
  logic [CHANNEL_BITS-1:0] op_q;

  assign in_ready  = !sel_valid_r || sel_ready;
  assign sel_ready = !num_valid_r || out_ready;
  assign out_valid = num_valid_r;
  assign out_data  = num_r;

  // Pick max, min and the sector with red over green over blue on ties
  always_comb begin
    vmax = in_red;
    if (in_green > vmax) vmax = in_green;
    if (in_blue > vmax) vmax = in_blue;
    vmin = in_red;
    if (in_green < vmin) vmin = in_green;
    if (in_blue < vmin) vmin = in_blue;

    if (in_red == vmax) begin
      sel_nxt.sector = SECT_RED;
      op_p = in_green;
      op_q = in_blue;
    end else if (in_green == vmax) begin
      sel_nxt.sector = SECT_GREEN;
      op_p = in_blue;
      op_q = in_red;
    end else begin
      sel_nxt.sector = SECT_BLUE;
      op_p = in_red;
      op_q = in_green;
    end

    sel_nxt.vmax    = vmax;
    sel_nxt.delta   = vmax - vmin;
    sel_nxt.neg     = (op_p < op_q);
    sel_nxt.absdiff = (op_p < op_q) ? (op_q - op_p) : (op_p - op_q);
  end

  // Form the numerators: SECTOR*|diff| for hue, CHAN_MAX*delta for saturation
  always_comb begin
    num_nxt.hue_acc = ACC_BITS'(sel_r.absdiff) * ACC_BITS'(SECTOR);
    num_nxt.sat_acc = ACC_BITS'(sel_r.delta) * ACC_BITS'(CHAN_MAX);
    num_nxt.delta   = sel_r.delta;
    num_nxt.vmax    = sel_r.vmax;
    num_nxt.sector  = sel_r.sector;
    num_nxt.neg     = sel_r.neg;
    num_nxt.flat    = (sel_r.delta == '0);
  end

  // Advance each stage when the next one can take it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_valid_r <= 1'b0;
      num_valid_r <= 1'b0;
    end else begin
      if (in_ready) sel_valid_r <= in_valid;
      if (sel_ready) num_valid_r <= sel_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) sel_r <= sel_nxt;
    if (sel_ready && sel_valid_r) num_r <= num_nxt;
  end

endmodule

// ===== hw/rtl/rhsv_div_step.sv =====
// One restoring-division stage: one quotient bit each for hue and saturation.
module rhsv_div_step
  import rhsv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  rhsv_stage_t in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output rhsv_stage_t out_data
);

  logic        valid_r;
  rhsv_stage_t data_r;
  rhsv_stage_t data_nxt;

  // Shift in one numerator bit, subtract the divisor when it fits
  function automatic logic [ACC_BITS-1:0] div_bit(input logic [ACC_BITS-1:0] acc,
                                                  input logic [CHANNEL_BITS-1:0] div);
    logic [ACC_BITS:0]       sh;
    logic [CHANNEL_BITS:0]   hi;
    logic [DIV_STEPS-1:0]    lo;
    sh = {acc, 1'b0};
    hi = sh[ACC_BITS:DIV_STEPS];
    lo = sh[DIV_STEPS-1:0];
    if (hi >= {1'b0, div}) begin
      hi    = hi - {1'b0, div};
      lo[0] = 1'b1;
    end
    return {hi[CHANNEL_BITS-1:0], lo};
  endfunction

  always_comb begin
    data_nxt         = in_data;
    data_nxt.hue_acc = div_bit(in_data.hue_acc, in_data.delta);
    data_nxt.sat_acc = div_bit(in_data.sat_acc, in_data.vmax);
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) data_r <= data_nxt;
  end

  // Partial remainders stay below their divisors
  a_hue_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && data_r.delta != '0) |->
      (data_r.hue_acc[ACC_BITS-1:DIV_STEPS] < data_r.delta))
    else $error("hue partial remainder not below divisor");

  a_sat_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && data_r.vmax != '0) |->
      (data_r.sat_acc[ACC_BITS-1:DIV_STEPS] < data_r.vmax))
    else $error("saturation partial remainder not below divisor");

endmodule

// ===== hw/rtl/rhsv_back.sv =====
// Back end: hue from sector and quotient with floor and wrap, output register.
module rhsv_back
  import rhsv_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  rhsv_stage_t             in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [HUE_BITS-1:0]     out_hue,
  output logic [CHANNEL_BITS-1:0] out_saturation,
  output logic [CHANNEL_BITS-1:0] out_brightness
);

  localparam int SW = HUE_BITS + 1;

  logic                    valid_r;
  logic [HUE_BITS-1:0]     hue_r;
  logic [HUE_BITS-1:0]     hue_nxt;
  logic [CHANNEL_BITS-1:0] sat_r;
  logic [CHANNEL_BITS-1:0] sat_nxt;
  logic [CHANNEL_BITS-1:0] bright_r;

  logic [DIV_STEPS-1:0]    quot;
  logic                    rem_nz;
  logic signed [SW-1:0]    base_val;
  logic signed [SW-1:0]    magn;
  logic signed [SW-1:0]    hue_s;

  // Negative offsets round toward minus infinity: bump magnitude on a remainder
  always_comb begin
    quot   = in_data.hue_acc[DIV_STEPS-1:0];
    rem_nz = (in_data.hue_acc[ACC_BITS-1:DIV_STEPS] != '0);
    case (in_data.sector)
      SECT_RED:   base_val = '0;
      SECT_GREEN: base_val = SW'(2 * SECTOR);
      SECT_BLUE:  base_val = SW'(4 * SECTOR);
      default:    base_val = '0;
    endcase
    magn  = $signed(SW'(quot) + SW'(in_data.neg && rem_nz));
    hue_s = in_data.neg ? (base_val - magn) : (base_val + magn);
    if (hue_s < 0) hue_s = hue_s + $signed(SW'(CIRCLE));

    if (in_data.flat) begin
      hue_nxt = '0;
      sat_nxt = '0;
    end else begin
      hue_nxt = hue_s[HUE_BITS-1:0];
      sat_nxt = in_data.sat_acc[CHANNEL_BITS-1:0];
    end
  end

  assign in_ready       = !valid_r || out_ready;
  assign out_valid      = valid_r;
  assign out_hue        = hue_r;
  assign out_saturation = sat_r;
  assign out_brightness = bright_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hue_r    <= hue_nxt;
      sat_r    <= sat_nxt;
      bright_r <= in_data.vmax;
    end
  end

endmodule

// ===== dv/rgb_to_hsv_pixel_unit_checker.sv =====
// Checker for the RGB to HSV pixel unit: predicts each pixel result and compares outputs.
`timescale 1ns / 100ps

module rgb_to_hsv_pixel_unit_checker
  import rhsv_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [CHANNEL_BITS-1:0] in_red,
  input  logic [CHANNEL_BITS-1:0] in_green,
  input  logic [CHANNEL_BITS-1:0] in_blue,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [HUE_BITS-1:0]     out_hue,
  input  logic [CHANNEL_BITS-1:0] out_saturation,
  input  logic [CHANNEL_BITS-1:0] out_brightness,
  output int                      mismatch_count,
  output int                      pending_pixels
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [HUE_BITS-1:0]     hue;
    logic [CHANNEL_BITS-1:0] saturation;
    logic [CHANNEL_BITS-1:0] brightness;
  } hsv_pixel_t;

  hsv_pixel_t expected_hsv[$];
  hsv_pixel_t want;
  int         bad_fields = 0;

  // Convert one pixel: brightness is the max, hue uses a floored sector division
  function automatic hsv_pixel_t predict_hsv(input logic [CHANNEL_BITS-1:0] r,
                                             input logic [CHANNEL_BITS-1:0] g,
                                             input logic [CHANNEL_BITS-1:0] b);
    hsv_pixel_t   px;
    int           ri, gi, bi, mx, mn, d, base, diff, num, q;
    rhsv_sector_t sect;
    ri = r;
    gi = g;
    bi = b;
    px = '0;
    mx = ri;
    mn = ri;
    if (gi > mx) mx = gi;
    if (bi > mx) mx = bi;
    if (gi < mn) mn = gi;
    if (bi < mn) mn = bi;
    d = mx - mn;
    if (d > 0) begin
      px.saturation = CHANNEL_BITS'((CHAN_MAX * d) / mx);
      // Red beats green beats blue on a tie for the largest channel
      if (ri == mx) sect = SECT_RED;
      else if (gi == mx) sect = SECT_GREEN;
      else sect = SECT_BLUE;
      case (sect)
        SECT_RED: begin
          base = 0;
          diff = gi - bi;
        end
        SECT_GREEN: begin
          base = 2;
          diff = bi - ri;
        end
        default: begin
          base = 4;
          diff = ri - gi;
        end
      endcase
      num = SECTOR * (base * d + diff);
      q = num / d;
      // Round toward minus infinity, then wrap negative hue onto the circle
      if (num < 0 && q * d != num) q = q - 1;
      if (q < 0) q = q + CIRCLE;
      px.hue = HUE_BITS'(q);
    end
    px.brightness = CHANNEL_BITS'(mx);
    return px;
  endfunction

  // Count one wrong field; report only the first few in detail
  task automatic note_mismatch(input string field, input int want_v, input int got_v);
    if (bad_fields < REPORT_LIMIT)
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want_v, got_v);
    bad_fields++;
  endtask

  // Queue a prediction per input transaction, check each output transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      expected_hsv.delete();
    end else begin
      if (in_valid && in_ready)
        expected_hsv = {expected_hsv, predict_hsv(in_red, in_green, in_blue)};
      if (out_valid && out_ready) begin
        if (expected_hsv.size() == 0) begin
          note_mismatch("unexpected result, hue", -1, int'(out_hue));
        end else begin
          want = expected_hsv.pop_front();
          if (out_hue !== want.hue)
            note_mismatch("hue", int'(want.hue), int'(out_hue));
          if (out_saturation !== want.saturation)
            note_mismatch("saturation", int'(want.saturation), int'(out_saturation));
          if (out_brightness !== want.brightness)
            note_mismatch("brightness", int'(want.brightness), int'(out_brightness));
        end
      end
    end
    pending_pixels <= expected_hsv.size();
    mismatch_count <= bad_fields;
  end

endmodule

// ===== dv/rgb_to_hsv_pixel_unit_test.sv =====
// Testbench top for the RGB to HSV pixel unit: stimulus, back-pressure and verdict.
`timescale 1ns / 100ps

module rgb_to_hsv_pixel_unit_test;
  import rhsv_pkg::*;

  localparam int RESET_CYCLES    = 10;
  localparam int PHASE_PIXELS    = 300;
  localparam int HOLD_OFF_CYCLES = 100;
  localparam int DRAIN_CYCLES    = 40;
  localparam int QUIET_LIMIT     = 2000;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [CHANNEL_BITS-1:0] in_red = '0;
  logic [CHANNEL_BITS-1:0] in_green = '0;
  logic [CHANNEL_BITS-1:0] in_blue = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [HUE_BITS-1:0]     out_hue;
  logic [CHANNEL_BITS-1:0] out_saturation;
  logic [CHANNEL_BITS-1:0] out_brightness;

  int   mismatch_count;
  int   pending_pixels;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic hold_off_go = 1'b0;
  logic hold_off_taken = 1'b0;
  int   quiet_cycles = 0;
  int   item;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rgb_to_hsv_pixel_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hue        (out_hue),
    .out_saturation (out_saturation),
    .out_brightness (out_brightness)
  );

  rgb_to_hsv_pixel_unit_checker checker_inst (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hue        (out_hue),
    .out_saturation (out_saturation),
    .out_brightness (out_brightness),
    .mismatch_count (mismatch_count),
    .pending_pixels (pending_pixels)
  );

  // Offer one pixel after a random gap and hold it until the transaction completes
  task automatic send_pixel(input logic [CHANNEL_BITS-1:0] r,
                            input logic [CHANNEL_BITS-1:0] g,
                            input logic [CHANNEL_BITS-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Pick a pixel: mostly random, with plenty of grey, ties and corner values
  task automatic offer_random_pixel();
    logic [CHANNEL_BITS-1:0] r, g, b, top_v, low_v;
    int                      kind;
    kind = $urandom_range(99);
    r = CHANNEL_BITS'($urandom_range(255));
    g = CHANNEL_BITS'($urandom_range(255));
    b = CHANNEL_BITS'($urandom_range(255));
    if (kind < 10) begin
      g = r;
      b = r;
    end else if (kind < 25) begin
      top_v = CHANNEL_BITS'($urandom_range(255, 1));
      low_v = CHANNEL_BITS'($urandom_range(int'(top_v) - 1));
      case ($urandom_range(2))
        0: begin
          r = top_v;
          g = top_v;
          b = low_v;
        end
        1: begin
          r = low_v;
          g = top_v;
          b = top_v;
        end
        default: begin
          r = top_v;
          g = low_v;
          b = top_v;
        end
      endcase
    end else if (kind < 35) begin
      r = CHANNEL_BITS'($urandom_range(3));
      g = CHANNEL_BITS'($urandom_range(3));
      b = CHANNEL_BITS'($urandom_range(3));
    end else if (kind < 45) begin
      if ($urandom_range(1)) r = $urandom_range(1) ? '1 : '0;
      if ($urandom_range(1)) g = $urandom_range(1) ? '1 : '0;
      if ($urandom_range(1)) b = $urandom_range(1) ? '1 : '0;
    end
    send_pixel(r, g, b);
  endtask

  // Stop offering and wait until every predicted result has been checked
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels != 0) @(posedge clk);
  endtask

  // Result side: random stalls plus one long hold-off when requested
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_go && !hold_off_taken) begin
        hold_off_taken = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Abort when no transaction moves on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender idles lightly, receiver heavily
    send_idle_pct = 18;
    recv_idle_pct <= 53;

    // Grey levels, black and white give zero hue and saturation
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd1, 8'd1, 8'd1);
    // Primaries and single-step channels
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd1, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd1);
    // Ties for the largest channel
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd1, 8'd1, 8'd0);
    // Red sector: blue above green wraps round the circle, green above blue does not
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd128, 8'd129);
    send_pixel(8'd255, 8'd1, 8'd0);
    // Near-grey and mid-range mixes across all sectors
    send_pixel(8'd255, 8'd254, 8'd253);
    send_pixel(8'd254, 8'd255, 8'd1);
    send_pixel(8'd1, 8'd254, 8'd255);
    send_pixel(8'd170, 8'd85, 8'd255);
    send_pixel(8'd85, 8'd170, 8'd0);
    send_pixel(8'd2, 8'd1, 8'd0);
    send_pixel(8'd0, 8'd128, 8'd255);

    for (item = 0; item < PHASE_PIXELS; item++) offer_random_pixel();
    drain_pipeline();

    // Swap the idling of the two sides
    send_idle_pct = 53;
    recv_idle_pct <= 18;
    for (item = 0; item < PHASE_PIXELS; item++) offer_random_pixel();
    drain_pipeline();

    // Full rate, opened by a long result stall to back up the pipeline
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    hold_off_go <= 1'b1;
    for (item = 0; item < PHASE_PIXELS; item++) offer_random_pixel();
    drain_pipeline();

    // Allow any stray result to surface before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
